FILE: design/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and status codes of the time-span floor divider.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int FIELD_WIDTH = 64;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] dividend;
        logic signed [FIELD_WIDTH-1:0] divisor;
        logic                          last_in;
    } tfd_in_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] quotient;
        status_t                       status;
        logic                          last_out;
    } tfd_out_t;

    // control that rides along with each word through the cell chain
    typedef struct packed {
        status_t status;
        logic    neg;
        logic    last;
    } tfd_side_t;

endpackage

FILE: design/tfd_prep.sv
// ----------------------------------------------------------------------------
// tfd_prep
// Operand check and magnitude forming ahead of the division chain.
// ----------------------------------------------------------------------------
module tfd_prep import tfd_pkg::*; #(
    parameter int W = 64
) (
    input  tfd_in_t         in_word,
    output tfd_side_t       side,
    output logic [W-1:0]    mag_a,
    output logic [W-1:0]    mag_b
);

    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] nat;

    assign a   = in_word.dividend[W-1:0];
    assign b   = in_word.divisor[W-1:0];
    assign nat = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        side.last = in_word.last_in;
        side.neg  = a[W-1] ^ b[W-1];
        if (a == nat || b == nat) begin
            side.status = STATUS_INVALID;
        end else if (b == '0) begin
            side.status = STATUS_DIV_ZERO;
        end else begin
            side.status = STATUS_OK;
        end
        mag_a = a[W-1] ? (~a + 1'b1) : a;
        mag_b = b[W-1] ? (~b + 1'b1) : b;
    end

endmodule

FILE: design/tfd_cell.sv
// ----------------------------------------------------------------------------
// tfd_cell
// One restoring division step: shifts in a dividend bit, trial subtracts,
// and registers the partial remainder and quotient bit for the next cell.
// ----------------------------------------------------------------------------
module tfd_cell import tfd_pkg::*; #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  tfd_side_t    in_side,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_acc,
    input  logic [W-1:0] in_dsr,
    output logic         out_valid,
    output tfd_side_t    out_side,
    output logic [W-1:0] out_rem,
    output logic [W-1:0] out_acc,
    output logic [W-1:0] out_dsr
);

    logic            valid_reg;
    tfd_side_t       side_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    rem_next;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    acc_next;
    logic [W-1:0]    dsr_reg;
    logic [W-1:0]    partial;
    logic [W:0]      diff;
    logic            take;

    always_comb begin
        partial  = {in_rem[W-2:0], in_acc[W-1]};
        diff     = {1'b0, partial} - {1'b0, in_dsr};
        take     = ~diff[W];
        rem_next = take ? diff[W-1:0] : partial;
        acc_next = {in_acc[W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            dsr_reg  <= in_dsr;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;
    assign out_dsr   = dsr_reg;

endmodule

FILE: design/tfd_post.sv
// ----------------------------------------------------------------------------
// tfd_post
// Applies the sign and floor correction and forms the result word.
// ----------------------------------------------------------------------------
module tfd_post import tfd_pkg::*; #(
    parameter int W = 64
) (
    input  tfd_side_t    side,
    input  logic [W-1:0] uq,
    input  logic [W-1:0] rem,
    output tfd_out_t     out_word
);

    logic signed [W-1:0] q;

    always_comb begin
        if (side.status != STATUS_OK) begin
            q = '0;
        end else if (side.neg) begin
            // floor of a negative inexact quotient: -uq - 1 == ~uq
            q = (rem != '0) ? ~uq : (~uq + 1'b1);
        end else begin
            q = uq;
        end
        out_word.quotient = FIELD_WIDTH'(q);
        out_word.status   = side.status;
        out_word.last_out = side.last;
    end

endmodule

FILE: design/timedelta_floor_divide_core.sv
// ----------------------------------------------------------------------------
// timedelta_floor_divide_core
// Signed floor division of time spans, one result word per input word.
//
//   port group   dir   handshake          payload
//   s_           in    s_valid/s_ready    s_word   (tfd_in_t)
//   m_           out   m_valid/m_ready    m_word   (tfd_out_t)
//
// A word passes through DATA_WIDTH division cells, one quotient bit per
// cell, then the output register.
// A new word is taken every cycle while the output side keeps up.
// When the output register holds a word that is not taken, the whole
// chain holds and s_ready drops in the same cycle.
// Reset clears only the valid flags of the cells and the output register.
// ----------------------------------------------------------------------------
module timedelta_floor_divide_core import tfd_pkg::*; #(
    parameter int DATA_WIDTH = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tfd_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output tfd_out_t m_word
);

    localparam int W = DATA_WIDTH;

    logic            adv;
    logic            valid_pipe [0:W];
    tfd_side_t       side_pipe  [0:W];
    logic [W-1:0]    rem_pipe   [0:W];
    logic [W-1:0]    acc_pipe   [0:W];
    logic [W-1:0]    dsr_pipe   [0:W];
    tfd_out_t        post_word;
    tfd_out_t        m_word_reg;
    logic            m_valid_reg;

    assign adv     = ~m_valid_reg | m_ready;
    assign s_ready = adv;

    assign valid_pipe[0] = s_valid;
    assign rem_pipe[0]   = '0;

    tfd_prep #(.W(W)) u_prep (
        .in_word (s_word),
        .side    (side_pipe[0]),
        .mag_a   (acc_pipe[0]),
        .mag_b   (dsr_pipe[0])
    );

    for (genvar i = 0; i < W; i++) begin : g_cell
        tfd_cell #(.W(W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (valid_pipe[i]),
            .in_side   (side_pipe[i]),
            .in_rem    (rem_pipe[i]),
            .in_acc    (acc_pipe[i]),
            .in_dsr    (dsr_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_side  (side_pipe[i+1]),
            .out_rem   (rem_pipe[i+1]),
            .out_acc   (acc_pipe[i+1]),
            .out_dsr   (dsr_pipe[i+1])
        );
    end

    tfd_post #(.W(W)) u_post (
        .side     (side_pipe[W]),
        .uq       (acc_pipe[W]),
        .rem      (rem_pipe[W]),
        .out_word (post_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= valid_pipe[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_word_reg <= post_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks timedelta_floor_divide_core against its own floor-division predictor.
// A driver sends division requests in bursts. A monitor compares every result
// word field by field with the oldest predicted word. The receiver stalls in
// changing patterns, with two long hold-offs, and the sender drains twice.
// ----------------------------------------------------------------------------
module testbench;
    import tfd_pkg::*;

    localparam int          DW          = 64;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          LONG_HOLD   = 300;
    localparam int          RAND_ITEMS  = 1150;
    localparam logic [63:0] NAT_SPAN    = {1'b1, 63'd0};
    localparam logic [63:0] MAX_SPAN    = {1'b0, {63{1'b1}}};
    localparam int          HOLD_AT [2] = '{200, 700};

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    typedef struct packed {
        tfd_in_t word;
        logic    wait_drain;
    } div_request_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tfd_in_t  s_word  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tfd_out_t m_word;

    div_request_t div_request_q[$];
    tfd_out_t     expected_quotient_q[$];
    int           error_count  = 0;
    int           result_count = 0;
    int           cycle_count  = 0;

    timedelta_floor_divide_core #(
        .DATA_WIDTH(DW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] sext_dw(logic [63:0] v);
        logic [63:0] mask;
        logic [63:0] sign;
        mask = ~64'd0 >> (64 - DW);
        sign = 64'd1 << (DW - 1);
        return ((v & mask) ^ sign) - sign;
    endfunction

    function automatic tfd_out_t floor_div_predict(tfd_in_t w);
        logic [63:0] nat, a, b, ma, mb, uq, ur, q;
        tfd_out_t    r;
        nat = sext_dw(64'd1 << (DW - 1));
        a = sext_dw(w.dividend);
        b = sext_dw(w.divisor);
        r = '0;
        r.status = STATUS_OK;
        r.last_out = w.last_in;
        if (a == nat || b == nat) begin
            r.status = STATUS_INVALID;
        end else if (b == 64'd0) begin
            r.status = STATUS_DIV_ZERO;
        end else begin
            ma = a[63] ? 64'd0 - a : a;
            mb = b[63] ? 64'd0 - b : b;
            uq = ma / mb;
            ur = ma % mb;
            if (a[63] != b[63]) begin
                q = 64'd0 - uq;
                if (ur != 64'd0) q = q - 64'd1;
            end else begin
                q = uq;
            end
            r.quotient = sext_dw(q);
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_span();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: v = NAT_SPAN;
            1: v = 64'd0;
            2: v = $urandom_range(0, 1) ? 64'd1 : ~64'd0;
            3: v = $urandom_range(0, 1) ? MAX_SPAN : NAT_SPAN + 64'd1;
            4, 5, 6: v = 64'($urandom_range(0, 2000)) - 64'd1000;
            7, 8, 9: begin
                v = v >> $urandom_range(1, 62);
                if ($urandom_range(0, 1)) v = 64'd0 - v;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_request(logic [63:0] dividend, logic [63:0] divisor, logic last,
                               logic wait_drain);
        div_request_t r;
        r.word.dividend = dividend;
        r.word.divisor = divisor;
        r.word.last_in = last;
        r.wait_drain = wait_drain;
        div_request_q.push_back(r);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge aclk) begin : driver
        logic busy;
        int   burst_left;
        int   gap_left;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_word <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                expected_quotient_q.push_back(floor_div_predict(s_word));
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (div_request_q.size() != 0 &&
                             (!div_request_q[0].wait_drain ||
                              expected_quotient_q.size() == 0)) begin
                    s_word <= div_request_q[0].word;
                    void'(div_request_q.pop_front());
                    busy = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_valid <= busy;
        end
    end

    // receiver: random stall patterns that change over time, plus long holds
    always @(posedge aclk) begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       hold_idx;
        int       phase;
        if (!aresetn) begin
            m_ready <= 1'b0;
            mode = RX_ALWAYS;
            mode_left = 0;
            hold_left = 0;
            hold_idx = 0;
            phase = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_idx < 2 && result_count >= HOLD_AT[hold_idx]) begin
            hold_left = LONG_HOLD;
            hold_idx++;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            phase = (phase + 1) % 5;
            case (mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_COIN:    m_ready <= $urandom_range(0, 1);
                RX_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: m_ready <= (phase < 3);
                default:    m_ready <= 1'b1;
            endcase
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin : monitor
        tfd_out_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_quotient_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_word);
                error_count++;
            end else begin
                exp_word = expected_quotient_q.pop_front();
                if (m_word.quotient !== exp_word.quotient) begin
                    $display("%0t: quotient expected %0d actual %0d", $time,
                             exp_word.quotient, m_word.quotient);
                    error_count++;
                end
                if (m_word.status !== exp_word.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_word.status, m_word.status);
                    error_count++;
                end
                if (m_word.last_out !== exp_word.last_out) begin
                    $display("%0t: last_out expected %b actual %b", $time,
                             exp_word.last_out, m_word.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] a;
        logic [63:0] b;
        // not-a-time, divide-by-zero and a zero dividend
        add_request(NAT_SPAN, 64'd5, 1'b0, 1'b0);
        add_request(64'd5, NAT_SPAN, 1'b1, 1'b0);
        add_request(NAT_SPAN, NAT_SPAN, 1'b0, 1'b0);
        add_request(NAT_SPAN, 64'd0, 1'b1, 1'b0);
        add_request(64'd17, 64'd0, 1'b0, 1'b0);
        add_request(64'd0, 64'd0, 1'b0, 1'b0);
        add_request(64'd0, -64'd3, 1'b0, 1'b0);
        // extremes
        add_request(MAX_SPAN, 64'd1, 1'b0, 1'b0);
        add_request(MAX_SPAN, ~64'd0, 1'b1, 1'b0);
        add_request(NAT_SPAN + 64'd1, ~64'd0, 1'b0, 1'b0);
        add_request(NAT_SPAN + 64'd1, 64'd1, 1'b0, 1'b0);
        add_request(MAX_SPAN, MAX_SPAN, 1'b0, 1'b0);
        add_request(NAT_SPAN + 64'd1, MAX_SPAN, 1'b0, 1'b0);
        add_request(MAX_SPAN, NAT_SPAN + 64'd1, 1'b0, 1'b0);
        add_request(~64'd0, MAX_SPAN, 1'b0, 1'b0);
        add_request(64'd1, NAT_SPAN + 64'd1, 1'b0, 1'b0);
        // rounding toward minus infinity
        add_request(-64'd7, 64'd2, 1'b0, 1'b0);
        add_request(64'd7, -64'd2, 1'b0, 1'b0);
        add_request(-64'd7, -64'd2, 1'b0, 1'b0);
        add_request(64'd7, 64'd2, 1'b0, 1'b0);
        add_request(-64'd6, 64'd3, 1'b1, 1'b0);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            b = rand_span();
            a = rand_span();
            if ($urandom_range(0, 7) == 0) a = b * 64'($urandom_range(0, 5000));
            add_request(a, b, ($urandom_range(0, 15) == 0), (i % 400 == 399));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (div_request_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_quotient_q.size() != 0) @(posedge aclk);
        repeat (DW + 20) @(posedge aclk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/tfd_pkg.sv
design/tfd_prep.sv
design/tfd_cell.sv
design/tfd_post.sv
design/timedelta_floor_divide_core.sv
sim/testbench.sv
